// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/rbd_pkg.sv =====
// Package for the RGBA box downscaler: payload structs, stage control structs
// and fixed constants. No dependencies.
`default_nettype none

package rbd_pkg;

   // Fixed field and counter widths
   localparam int PIX_W    = 8;
   localparam int PIX_MAX  = 255;
   localparam int NUM_CH   = 4;
   localparam int POS_W    = 13;
   localparam int END_W    = 15;
   localparam int CSR_IDX_W = 1;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 1'b1;
   localparam logic [POS_W-1:0]     SIZE_RESET        = 13'd64;

   typedef struct packed {
      logic [PIX_W-1:0] red_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] blue_in;
      logic [PIX_W-1:0] alpha_in;
   } pixel_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_out;
      logic [PIX_W-1:0] green_out;
      logic [PIX_W-1:0] blue_out;
      logic [PIX_W-1:0] alpha_out;
      logic             frame_end;
   } thumb_type;

   // Control of a block-row segment entering the accumulate stage
   typedef struct packed {
      logic valid;
      logic first_row;
      logic emit;
      logic last;
   } seg_ctl_type;

   // Control of a finished block sum entering the divide stage
   typedef struct packed {
      logic valid;
      logic last;
   } sum_ctl_type;

endpackage

`default_nettype wire

// ===== src/rgba_box_downscale_top.sv =====
// RGBA box-filter downscaler: takes source pixels in raster order and emits
// one thumbnail pixel per SCALE_FACTOR x SCALE_FACTOR block.
// Usage:
//   req_* carries one source pixel per transaction (valid/stall handshake).
//   rsp_* carries one thumbnail pixel per transaction; frame_end marks the
//   last thumbnail pixel of a frame. Partial blocks at the right and bottom
//   edges produce nothing.
//   csr_* writes source_width (index 0) and source_height (index 1); write
//   only while the block is idle. Both reset to 64.
// Throughput: one pixel per clock while no result waits under stall. The
//   three-register pipeline (segment register, block-sum register, result
//   register) moves as a whole. The thumbnail pixel of a block is valid in the
//   result register once its last source pixel has passed the segment and block-sum registers.
// Stall: rsp_stall holds the result register and freezes the pipeline; while
//   a result waits under stall, req_stall is high. With no stalled result the
//   block takes a pixel every cycle.
// Reset: synchronous; clears positions, sums and pipeline valids and restores
//   the size registers. The line memory needs no clearing: each block row
//   overwrites it on its first source row.
// Depends on rbd_pkg, rbd_track, rbd_accum and rbd_divide.
`default_nettype none

module rgba_box_downscale_top
   import rbd_pkg::*;
#(
   parameter int SCALE_FACTOR     = 4,
   parameter int MAX_SOURCE_WIDTH = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire pixel_type             req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output thumb_type                  rsp_data,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [POS_W-1:0]      csr_data
);

   localparam int ADDR_W = $clog2(MAX_SOURCE_WIDTH / SCALE_FACTOR);
   localparam int HSUM_W = $clog2(SCALE_FACTOR * PIX_MAX + 1);
   localparam int ACC_W  = $clog2(SCALE_FACTOR * SCALE_FACTOR * PIX_MAX + 1);

   logic                          advance, accept, rd_en;
   logic [ADDR_W-1:0]             rd_addr, seg_addr;
   seg_ctl_type                   seg_ctl;
   logic [NUM_CH-1:0][HSUM_W-1:0] seg_hsum;
   sum_ctl_type                   sum_ctl;
   logic [NUM_CH-1:0][ACC_W-1:0]  sum_data;

   // Pipeline moves unless a result waits under stall
   assign advance   = !rsp_valid || !rsp_stall;
   assign accept    = req_valid && advance;
   assign req_stall = !advance;

   rbd_track #(
      .SCALE_FACTOR     (SCALE_FACTOR),
      .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (accept),
      .advance   (advance),
      .pixel     (req_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .seg_ctl   (seg_ctl),
      .seg_addr  (seg_addr),
      .seg_hsum  (seg_hsum)
   );

   rbd_accum #(
      .SCALE_FACTOR     (SCALE_FACTOR),
      .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH)
   ) u_accum (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .seg_ctl  (seg_ctl),
      .seg_addr (seg_addr),
      .seg_hsum (seg_hsum),
      .sum_ctl  (sum_ctl),
      .sum_data (sum_data)
   );

   rbd_divide #(
      .SCALE_FACTOR (SCALE_FACTOR)
   ) u_divide (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .sum_ctl   (sum_ctl),
      .sum_data  (sum_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== src/rbd_track.sv =====
// Position tracking, configuration registers and horizontal sums of the
// box downscaler. Depends on rbd_pkg.
`default_nettype none

module rbd_track
   import rbd_pkg::*;
#(
   parameter int SCALE_FACTOR     = 4,
   parameter int MAX_SOURCE_WIDTH = 4096,
   localparam int SUB_W  = $clog2(SCALE_FACTOR),
   localparam int ADDR_W = $clog2(MAX_SOURCE_WIDTH / SCALE_FACTOR),
   localparam int HSUM_W = $clog2(SCALE_FACTOR * PIX_MAX + 1)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [CSR_IDX_W-1:0]           csr_index,
   input  wire logic [POS_W-1:0]               csr_data,
   input  wire logic                           accept,
   input  wire logic                           advance,
   input  wire pixel_type                      pixel,
   output logic                                rd_en,
   output logic [ADDR_W-1:0]                   rd_addr,
   output seg_ctl_type                         seg_ctl,
   output logic [ADDR_W-1:0]                   seg_addr,
   output logic [NUM_CH-1:0][HSUM_W-1:0]       seg_hsum
);

   localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(SCALE_FACTOR - 1);
   localparam logic [END_W-1:0] STEP     = END_W'(SCALE_FACTOR);
   localparam logic [END_W-1:0] MAX_COLS = END_W'(MAX_SOURCE_WIDTH);

   logic [POS_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [POS_W-1:0] col_ff, col_in, row_ff, row_in, bx_ff, bx_in;
   logic [SUB_W-1:0] subx_ff, subx_in, suby_ff, suby_in;
   logic [END_W-1:0] xend_ff, xend_in, yend_ff, yend_in;
   logic [NUM_CH-1:0][HSUM_W-1:0] hsum_ff, hsum_in;
   seg_ctl_type      seg_ctl_ff, seg_ctl_in;
   logic [ADDR_W-1:0] seg_addr_ff;
   logic [NUM_CH-1:0][HSUM_W-1:0] seg_hsum_ff;

   logic [POS_W-1:0] width_eff, height_eff;
   logic [END_W-1:0] xlimit, w_ext, h_ext;
   logic             col_wrap, row_wrap, in_block, seg_end, last_block;
   logic [NUM_CH-1:0][PIX_W-1:0] px;

   // Configuration writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  width_in  = csr_data;
            CSR_SOURCE_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   // Zero size acts as one; line memory caps the usable columns
   always_comb begin
      width_eff  = (width_ff == '0) ? POS_W'(1) : width_ff;
      height_eff = (height_ff == '0) ? POS_W'(1) : height_ff;
      w_ext      = END_W'(width_eff);
      h_ext      = END_W'(height_eff);
      xlimit     = (w_ext < MAX_COLS) ? w_ext : MAX_COLS;
   end

   // Block membership and end-of-frame block
   always_comb begin
      in_block   = (xend_ff <= xlimit) && (yend_ff <= h_ext);
      seg_end    = in_block && (subx_ff == SUB_LAST);
      last_block = ((xend_ff + STEP) > xlimit) && ((yend_ff + STEP) > h_ext);
      col_wrap   = (END_W'(col_ff) + END_W'(1)) >= w_ext;
      row_wrap   = (END_W'(row_ff) + END_W'(1)) >= h_ext;
   end

   // Advance the raster position and block counters
   always_comb begin
      col_in  = col_ff;
      subx_in = subx_ff;
      bx_in   = bx_ff;
      xend_in = xend_ff;
      row_in  = row_ff;
      suby_in = suby_ff;
      yend_in = yend_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in  = '0;
            subx_in = '0;
            bx_in   = '0;
            xend_in = STEP;
            if (row_wrap) begin
               row_in  = '0;
               suby_in = '0;
               yend_in = STEP;
            end else begin
               row_in = row_ff + POS_W'(1);
               if (suby_ff == SUB_LAST) begin
                  suby_in = '0;
                  yend_in = yend_ff + STEP;
               end else begin
                  suby_in = suby_ff + SUB_W'(1);
               end
            end
         end else begin
            col_in = col_ff + POS_W'(1);
            if (subx_ff == SUB_LAST) begin
               subx_in = '0;
               bx_in   = bx_ff + POS_W'(1);
               xend_in = xend_ff + STEP;
            end else begin
               subx_in = subx_ff + SUB_W'(1);
            end
         end
      end
   end

   // Horizontal running sums over the current block segment
   assign px[0] = pixel.red_in;
   assign px[1] = pixel.green_in;
   assign px[2] = pixel.blue_in;
   assign px[3] = pixel.alpha_in;

   always_comb begin
      hsum_in = hsum_ff;
      if (accept && in_block) begin
         for (int c = 0; c < NUM_CH; c++) begin
            hsum_in[c] = (subx_ff == '0) ? HSUM_W'(px[c])
                                         : hsum_ff[c] + HSUM_W'(px[c]);
         end
      end
   end

   // Segment control for the accumulate stage
   always_comb begin
      seg_ctl_in           = seg_ctl_ff;
      if (advance) begin
         seg_ctl_in.valid     = accept && seg_end;
         seg_ctl_in.first_row = (suby_ff == '0);
         seg_ctl_in.emit      = (suby_ff == SUB_LAST);
         seg_ctl_in.last      = last_block;
      end
   end

   assign rd_en   = accept && seg_end && (suby_ff != '0);
   assign rd_addr = bx_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= SIZE_RESET;
         height_ff  <= SIZE_RESET;
         col_ff     <= '0;
         row_ff     <= '0;
         bx_ff      <= '0;
         subx_ff    <= '0;
         suby_ff    <= '0;
         xend_ff    <= STEP;
         yend_ff    <= STEP;
         hsum_ff    <= '0;
         seg_ctl_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         bx_ff      <= bx_in;
         subx_ff    <= subx_in;
         suby_ff    <= suby_in;
         xend_ff    <= xend_in;
         yend_ff    <= yend_in;
         hsum_ff    <= hsum_in;
         seg_ctl_ff <= seg_ctl_in;
      end
   end

   // Segment payload: hold while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         seg_addr_ff <= bx_ff[ADDR_W-1:0];
         seg_hsum_ff <= hsum_in;
      end
   end

   assign seg_ctl  = seg_ctl_ff;
   assign seg_addr = seg_addr_ff;
   assign seg_hsum = seg_hsum_ff;

endmodule

`default_nettype wire

// ===== src/rbd_accum.sv =====
// Line accumulator memory and vertical summing stage of the box downscaler.
// Depends on rbd_pkg.
`default_nettype none

module rbd_accum
   import rbd_pkg::*;
#(
   parameter int SCALE_FACTOR     = 4,
   parameter int MAX_SOURCE_WIDTH = 4096,
   localparam int ADDR_W = $clog2(MAX_SOURCE_WIDTH / SCALE_FACTOR),
   localparam int HSUM_W = $clog2(SCALE_FACTOR * PIX_MAX + 1),
   localparam int ACC_W  = $clog2(SCALE_FACTOR * SCALE_FACTOR * PIX_MAX + 1)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic                           rd_en,
   input  wire logic [ADDR_W-1:0]              rd_addr,
   input  wire seg_ctl_type                    seg_ctl,
   input  wire logic [ADDR_W-1:0]              seg_addr,
   input  wire logic [NUM_CH-1:0][HSUM_W-1:0]  seg_hsum,
   output sum_ctl_type                         sum_ctl,
   output logic [NUM_CH-1:0][ACC_W-1:0]        sum_data
);

   localparam int LINE_DEPTH = MAX_SOURCE_WIDTH / SCALE_FACTOR;

   logic [NUM_CH-1:0][ACC_W-1:0] line_mem [LINE_DEPTH];
   logic [NUM_CH-1:0][ACC_W-1:0] rd_data_ff;
   logic [NUM_CH-1:0][ACC_W-1:0] acc_in;
   logic [NUM_CH-1:0][ACC_W-1:0] sum_data_ff;
   sum_ctl_type                  sum_ctl_ff, sum_ctl_in;

   // Fetch the partial column sum when a segment closes below the first row
   always_ff @(posedge clock) begin
      if (advance && rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   // Start or extend the vertical sum
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         acc_in[c] = seg_ctl.first_row ? ACC_W'(seg_hsum[c])
                                       : rd_data_ff[c] + ACC_W'(seg_hsum[c]);
      end
   end

   // Write back the updated column sum as the segment leaves
   always_ff @(posedge clock) begin
      if (advance && seg_ctl.valid) begin
         line_mem[seg_addr] <= acc_in;
      end
   end

   always_comb begin
      sum_ctl_in = sum_ctl_ff;
      if (advance) begin
         sum_ctl_in.valid = seg_ctl.valid && seg_ctl.emit;
         sum_ctl_in.last  = seg_ctl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ctl_ff <= '0;
      end else begin
         sum_ctl_ff <= sum_ctl_in;
      end
   end

   // Block sum payload: hold while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         sum_data_ff <= acc_in;
      end
   end

   assign sum_ctl  = sum_ctl_ff;
   assign sum_data = sum_data_ff;

endmodule

`default_nettype wire

// ===== src/rbd_divide.sv =====
// Mean computation and result register of the box downscaler: divides each
// block sum by the block area with a reciprocal multiply. Depends on rbd_pkg.
`default_nettype none

module rbd_divide
   import rbd_pkg::*;
#(
   parameter int SCALE_FACTOR = 4,
   localparam int ACC_W = $clog2(SCALE_FACTOR * SCALE_FACTOR * PIX_MAX + 1)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire sum_ctl_type                    sum_ctl,
   input  wire logic [NUM_CH-1:0][ACC_W-1:0]   sum_data,
   output logic                                rsp_valid,
   output thumb_type                           rsp_data
);

   // floor(x / AREA) == (x * RECIP) >> SHIFT for every x below 2**ACC_W
   localparam int AREA    = SCALE_FACTOR * SCALE_FACTOR;
   localparam int SHIFT   = ACC_W + $clog2(AREA);
   localparam int RECIP   = ((1 << SHIFT) + AREA - 1) / AREA;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W  = ACC_W + RECIP_W;

   logic [NUM_CH-1:0][PROD_W-1:0] prod;
   logic [NUM_CH-1:0][PIX_W-1:0]  mean;
   logic                          rsp_valid_ff, rsp_valid_in;
   thumb_type                     rsp_data_ff;

   // Reciprocal multiply, one lane per channel
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         prod[c] = PROD_W'(sum_data[c]) * PROD_W'(RECIP);
         mean[c] = prod[c][SHIFT +: PIX_W];
      end
   end

   assign rsp_valid_in = advance ? sum_ctl.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.red_out   <= mean[0];
         rsp_data_ff.green_out <= mean[1];
         rsp_data_ff.blue_out  <= mean[2];
         rsp_data_ff.alpha_out <= mean[3];
         rsp_data_ff.frame_end <= sum_ctl.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== src/rbd_checker.sv =====
// Port-level checker for the box downscaler, bound to the top level.
// Depends on rbd_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module rbd_checker
   import rbd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_stall,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire thumb_type             rsp_data
);

   // Reset leaves no result pending
   `ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // Input side is only held back by a stalled result
   `ASSERT_SAME(a_stall_cause, clock, reset, !(rsp_valid && rsp_stall), !req_stall,
      "input stalled with no stalled result")

   // A stalled result keeps its value
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind rgba_box_downscale_top rbd_checker u_rbd_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_rgba_box_downscale_top.sv =====
// Self-checking testbench for rgba_box_downscale_top: streams RGBA pixels through the
// box downscaler and checks every thumbnail pixel against a local prediction.
// Depends on rbd_pkg and rgba_box_downscale_top.
`default_nettype none

module tb_rgba_box_downscale_top;
   import rbd_pkg::*;

   localparam int BLOCK       = 4;
   localparam int LINE_BLOCKS = 4096 / BLOCK;

   typedef enum {CHK_MODEL, CHK_NONE, CHK_THUMB} chk_kind_type;

   // One row of the directed stimulus: a size change or one pixel
   typedef struct {
      bit           is_cfg;
      int unsigned  w;
      int unsigned  h;
      pixel_type    px;
      chk_kind_type how;
      thumb_type    want;
   } step_row_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   pixel_type            req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   thumb_type            rsp_data;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SOURCE_WIDTH;
   logic [POS_W-1:0]     csr_data  = '0;

   // Predicted block state
   logic [POS_W-1:0] cfg_w = SIZE_RESET;
   logic [POS_W-1:0] cfg_h = SIZE_RESET;
   int unsigned      pos_col = 0;
   int unsigned      pos_row = 0;
   logic [9:0]       seg_sum [4];
   logic [11:0]      col_acc [LINE_BLOCKS][4];

   thumb_type   thumb_q [$];
   int          err_cnt = 0;
   int          send_gap_pct = 27;
   int          rsp_stall_pct = 69;
   int unsigned pixels_sent = 0;

   rgba_box_downscale_top #(
      .SCALE_FACTOR     (BLOCK),
      .MAX_SOURCE_WIDTH (4096)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Fold one accepted pixel into the predicted state; flag a finished block
   task automatic fold_pixel(input pixel_type p, output bit fires, output thumb_type t);
      int unsigned w, h, bcols, brows, sx, sy, bx, by;
      logic [7:0]  px [4];
      logic [7:0]  mean [4];
      int          c;
      px[0] = p.red_in;
      px[1] = p.green_in;
      px[2] = p.blue_in;
      px[3] = p.alpha_in;
      w = (cfg_w == 0) ? 1 : cfg_w;
      h = (cfg_h == 0) ? 1 : cfg_h;
      bcols = w / BLOCK;
      if (bcols > LINE_BLOCKS) bcols = LINE_BLOCKS;
      brows = h / BLOCK;
      sx = pos_col % BLOCK;
      sy = pos_row % BLOCK;
      bx = pos_col / BLOCK;
      by = pos_row / BLOCK;
      fires = 1'b0;
      t = '0;
      if (bx < bcols && by < brows) begin
         for (c = 0; c < 4; c++) begin
            seg_sum[c] = (sx == 0) ? 10'(px[c]) : seg_sum[c] + px[c];
            if (sx == BLOCK - 1) begin
               col_acc[bx][c] = (sy == 0) ? 12'(seg_sum[c]) : col_acc[bx][c] + seg_sum[c];
               mean[c] = 8'(col_acc[bx][c] / (BLOCK * BLOCK));
            end
         end
         if (sx == BLOCK - 1 && sy == BLOCK - 1) begin
            fires = 1'b1;
            t.red_out   = mean[0];
            t.green_out = mean[1];
            t.blue_out  = mean[2];
            t.alpha_out = mean[3];
            t.frame_end = (bx == bcols - 1 && by == brows - 1);
         end
      end
      // Advance the raster position, wrap at the frame end
      if (pos_col + 1 >= w) begin
         pos_col = 0;
         pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
      end else begin
         pos_col = pos_col + 1;
      end
   endtask

   // Send one pixel transaction, then record what it should produce
   task automatic send_pixel(input pixel_type p, input chk_kind_type how,
                             input thumb_type want);
      bit        fires;
      thumb_type got;
      // Insert idle cycles at random with the current sender idle percentage
      while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
      fold_pixel(p, fires, got);
      case (how)
         CHK_MODEL: if (fires) thumb_q.push_back(got);
         CHK_THUMB: thumb_q.push_back(want);
         default: ;
      endcase
   endtask

   // Drop valid and hold until the pipeline has drained
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (thumb_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_size(input int unsigned w, input int unsigned h);
      csr_write <= 1'b1;
      csr_index <= CSR_SOURCE_WIDTH;
      csr_data  <= w[POS_W-1:0];
      @(posedge clock);
      cfg_w = w[POS_W-1:0];
      csr_index <= CSR_SOURCE_HEIGHT;
      csr_data  <= h[POS_W-1:0];
      @(posedge clock);
      cfg_h = h[POS_W-1:0];
      csr_write <= 1'b0;
   endtask

   // Style 1 keeps channels near full scale, style 2 near zero
   function automatic pixel_type rand_pixel(input int style);
      pixel_type p;
      p = $urandom;
      if (style == 1)
         p = {8'($urandom_range(240, 255)), 8'($urandom_range(240, 255)),
              8'($urandom_range(240, 255)), 8'($urandom_range(240, 255))};
      else if (style == 2)
         p = {8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
              8'($urandom_range(0, 15)), 8'($urandom_range(0, 15))};
      return p;
   endfunction

   // Mostly block-sized dimensions, some degenerate ones
   function automatic int unsigned pick_dim();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return 0;
      if (r < 10) return $urandom_range(1, 3);
      if (r < 85) return $urandom_range(4, 24);
      return $urandom_range(25, 70);
   endfunction

   // Advance to the start of a block row so a size change never reads a stale line entry
   task automatic pad_to_row_group(input int style);
      while (pos_col != 0 || pos_row % BLOCK != 0)
         send_pixel(rand_pixel(style), CHK_MODEL, '0);
   endtask

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         err_cnt++;
         $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endfunction

   // Check each accepted thumbnail transaction and draw the next stall
   always @(posedge clock) begin : rsp_check
      thumb_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (thumb_q.size() == 0) begin
            err_cnt++;
            $display("%0t: thumbnail pixel expected none got %h", $time, rsp_data);
         end else begin
            want = thumb_q.pop_front();
            check_field("red_out", want.red_out, rsp_data.red_out);
            check_field("green_out", want.green_out, rsp_data.green_out);
            check_field("blue_out", want.blue_out, rsp_data.blue_out);
            check_field("alpha_out", want.alpha_out, rsp_data.alpha_out);
            check_field("frame_end", 8'(want.frame_end), 8'(rsp_data.frame_end));
         end
      end
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(0, 99) < rsp_stall_pct);
   end

   initial begin
      #1_500_000;
      $display("tb_rgba_box_downscale_top: errors");
      $finish;
   end

   initial begin
      step_row_type steps [$];
      pixel_type    px;
      thumb_type    want;
      int unsigned  w, h, n, loop_base;
      int           style, i;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // One block row at the reset size of 64 x 64
      repeat (64 * BLOCK) send_pixel(rand_pixel($urandom_range(0, 2)), CHK_MODEL, '0);

      // Directed: one 4 x 4 frame with full scale, zero, half scale and truncated channels
      steps.push_back('{1'b1, 4, 4, '0, CHK_NONE, '0});
      for (i = 0; i < 16; i++) begin
         px = {8'hFF, 8'h00, (i % 2 == 1) ? 8'hFF : 8'h00, (i == 15) ? 8'hFF : 8'h00};
         want = {8'hFF, 8'h00, 8'h7F, 8'h0F, 1'b1};
         steps.push_back('{1'b0, 0, 0, px, (i == 15) ? CHK_THUMB : CHK_NONE, want});
      end
      // Zero size acts as one pixel: nothing comes out
      steps.push_back('{1'b1, 0, 0, '0, CHK_NONE, '0});
      steps.push_back('{1'b0, 0, 0, 32'hFFFF_FFFF, CHK_NONE, '0});
      steps.push_back('{1'b0, 0, 0, 32'h0000_0000, CHK_NONE, '0});
      steps.push_back('{1'b0, 0, 0, 32'hA5C3_5A3C, CHK_NONE, '0});
      steps.push_back('{1'b0, 0, 0, 32'hFF00_FF00, CHK_NONE, '0});
      foreach (steps[k]) begin
         if (steps[k].is_cfg) begin
            wait_idle();
            set_size(steps[k].w, steps[k].h);
            // Run out the current frame so the directed rows start at the top
            while (pos_col != 0 || pos_row != 0) send_pixel(rand_pixel(0), CHK_MODEL, '0);
         end else begin
            send_pixel(steps[k].px, steps[k].how, steps[k].want);
         end
      end

      // Random sizes and content, switching the idle pattern by thirds
      loop_base = pixels_sent;
      while (pixels_sent - loop_base < 1400) begin
         if (pixels_sent - loop_base >= 940) begin
            send_gap_pct  = 0;
            rsp_stall_pct = 0;
         end else if (pixels_sent - loop_base >= 470) begin
            send_gap_pct  = 69;
            rsp_stall_pct = 27;
         end
         style = $urandom_range(0, 3);
         pad_to_row_group(style);
         wait_idle();
         w = pick_dim();
         h = pick_dim();
         set_size(w, h);
         n = (w == 0) ? 1 : w;
         n = $urandom_range(4 * n, 12 * n);
         repeat (n) send_pixel(rand_pixel(style), CHK_MODEL, '0);
      end

      // Full-scale height register, narrow image, a few block rows only
      pad_to_row_group(0);
      wait_idle();
      set_size(4, 8191);
      repeat (BLOCK * BLOCK * 4) send_pixel(rand_pixel(3), CHK_MODEL, '0);

      wait_idle();
      if (err_cnt == 0)
         $display("tb_rgba_box_downscale_top: clean");
      else
         $display("tb_rgba_box_downscale_top: errors");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/rbd_pkg.sv
src/rbd_track.sv
src/rbd_accum.sv
src/rbd_divide.sv
src/rgba_box_downscale_top.sv
src/rbd_checker.sv
tb/sv/tb_rgba_box_downscale_top.sv
